// ===== hdl/rmrg_pkg.sv =====
// Shared types, constants and helper functions for the rotate-mix random generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rmrg_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RotW   = 5;
  localparam int unsigned RoundW = 6;

  // Additive constants of the seed step.
  localparam logic [WordW-1:0] SeedSubK = 32'h3501_4541;
  localparam logic [WordW-1:0] SeedAddK = 32'h2152_4110;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Four steps of one mixing round, one per cycle on the shared unit.
  typedef enum logic [1:0] {
    MIX_A,
    MIX_B,
    MIX_C,
    MIX_D
  } step_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_XOR
  } alu_op_t;

  typedef struct packed {
    logic  load_seed;
    logic  start_draw;
    logic  run;
    logic  finish;
    step_t step;
  } ctrl_t;

  // Left rotation; a zero amount leaves the word as it is.
  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] v,
                                              input logic [RotW-1:0] n);
    logic [2*WordW-1:0] d;
    d = {v, v} << n;
    return d[2*WordW-1:WordW];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rmrg_mix_unit.sv =====
// Shared mixing unit: one rotator followed by one add/subtract/XOR stage.
// Depends on rmrg_pkg for the step codes and the rotate function.
`default_nettype none

module rmrg_mix_unit
  import rmrg_pkg::*;
(
  input  var step_t            step_i,
  input  wire logic [WordW-1:0] w_i,
  input  wire logic [WordW-1:0] s_i,
  output logic [WordW-1:0]      w_o,
  output logic [WordW-1:0]      s_o
);

  logic [WordW-1:0] rot_src;
  logic [RotW-1:0]  rot_amt;
  logic [WordW-1:0] rot;
  logic [WordW-1:0] opa;
  logic [WordW-1:0] opb;
  alu_op_t          op;
  logic [WordW-1:0] alu;

  // Rotator input selection. A right rotation is a left rotation by the
  // negated amount.
  always_comb begin
    rot_src = w_i;
    rot_amt = s_i[4:0];
    unique case (step_i)
      MIX_A: begin
        rot_src = w_i;
        rot_amt = s_i[4:0];
      end
      MIX_B: begin
        rot_src = w_i;
        rot_amt = 5'd0 - s_i[31:27];
      end
      MIX_C: begin
        rot_src = s_i;
        rot_amt = w_i[9:5];
      end
      MIX_D: begin
        rot_src = w_i;
        rot_amt = s_i[17:13];
      end
    endcase
  end

  assign rot = rotl32(rot_src, rot_amt);

  // Operand and operation selection, and where the result goes.
  always_comb begin
    opa = rot;
    opb = s_i;
    op  = ALU_ADD;
    w_o = w_i;
    s_o = s_i;
    unique case (step_i)
      MIX_A: begin
        opa = s_i;
        opb = rot[0] ? SeedSubK : SeedAddK;
        op  = rot[0] ? ALU_SUB : ALU_ADD;
      end
      MIX_B: begin
        opa = rot;
        opb = s_i;
        op  = s_i[1] ? ALU_XOR : ALU_SUB;
      end
      MIX_C: begin
        opa = rot;
        opb = w_i;
        op  = w_i[2] ? ALU_ADD : ALU_XOR;
      end
      MIX_D: begin
        opa = s_i[3] ? rot : s_i;
        opb = s_i[3] ? s_i : rot;
        op  = s_i[3] ? ALU_ADD : ALU_SUB;
      end
    endcase

    unique case (op)
      ALU_ADD: alu = opa + opb;
      ALU_SUB: alu = opa - opb;
      ALU_XOR: alu = opa ^ opb;
      default: alu = opa;
    endcase

    unique case (step_i)
      MIX_A: begin
        w_o = rot;
        s_o = alu;
      end
      MIX_B: begin
        w_o = alu;
        s_o = s_i;
      end
      MIX_C: begin
        w_o = w_i;
        s_o = alu;
      end
      MIX_D: begin
        w_o = s_i[3] ? alu : rot;
        s_o = s_i[3] ? s_i : alu;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/rmrg_ctrl.sv =====
// Sequencer of the generator: handshake on the input side, step and round counters.
// Depends on rmrg_pkg for the state, step and control types.
`default_nettype none

module rmrg_ctrl
  import rmrg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  input  wire logic [4:0] round_sel,
  input  wire logic       out_free,
  output logic            in_ready,
  output ctrl_t           ctrl
);

  state_t            state_r, state_nxt;
  step_t             step_r, step_nxt;
  logic [RoundW-1:0] rnd_r, rnd_nxt;
  logic              accept;
  logic              last;

  assign accept = in_valid && in_ready;
  assign last   = (step_r == MIX_D) && (rnd_r == RoundW'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_mode) state_nxt = ST_RUN;
      ST_RUN:  if (last) state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready        = (state_r == ST_IDLE) && out_free;
    ctrl.load_seed  = accept && !in_mode;
    ctrl.start_draw = accept && in_mode;
    ctrl.run        = (state_r == ST_RUN);
    ctrl.finish     = (state_r == ST_RUN) && last;
    ctrl.step       = step_r;
  end

  // Step and round counters; the round count is 32 plus the low sample bits.
  always_comb begin
    step_nxt = step_r;
    rnd_nxt  = rnd_r;
    if (accept && in_mode) begin
      step_nxt = MIX_A;
      rnd_nxt  = {1'b1, round_sel};
    end else if (state_r == ST_RUN) begin
      unique case (step_r)
        MIX_A: step_nxt = MIX_B;
        MIX_B: step_nxt = MIX_C;
        MIX_C: step_nxt = MIX_D;
        MIX_D: begin
          step_nxt = MIX_A;
          rnd_nxt  = rnd_r - RoundW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= MIX_A;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rotate_mix_random_generator.sv =====
// Top level of the rotate-mix random generator: seed and working registers,
// result register. Depends on rmrg_pkg, rmrg_ctrl and rmrg_mix_unit.
//
//   Channel   Ports                                  Direction  Word
//   input     in_valid in_ready in_mode              in         mode and time sample
//             in_time_sample
//   result    out_valid out_ready out_random_word    out        one random word
//
// A seed load (mode 0) puts its zero word in the result register the cycle after
// it is accepted. A draw (mode 1) runs 32 to 63 rounds, the count being 32 plus
// the low five bits of the sample. Each round takes four steps on the single
// rotate and add/subtract/XOR unit, and the input stays not ready while the draw
// runs. A new word is accepted once the result register is empty or is emptied in
// that same cycle. Synchronous active-low reset clears the seed to zero and empties
// the result register. A stall on the result side only holds off the next word.
`default_nettype none

module rotate_mix_random_generator
  import rmrg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_mode,
  input  wire logic [WordW-1:0] in_time_sample,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WordW-1:0]      out_random_word
);

  ctrl_t            ctrl;
  logic             out_free;

  // The seed register doubles as the working seed during a draw; at the end
  // of the draw it already holds the updated seed.
  logic [WordW-1:0] s_r, s_nxt;
  logic [WordW-1:0] w_r, w_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_word_r, out_word_nxt;
  logic [WordW-1:0] mix_w;
  logic [WordW-1:0] mix_s;

  assign out_free = !out_valid_r || out_ready;

  rmrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .round_sel (in_time_sample[4:0]),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  rmrg_mix_unit u_mix (
    .step_i (ctrl.step),
    .w_i    (w_r),
    .s_i    (s_r),
    .w_o    (mix_w),
    .s_o    (mix_s)
  );

  // Working word and seed.
  always_comb begin
    w_nxt = w_r;
    s_nxt = s_r;
    if (ctrl.load_seed) begin
      s_nxt = in_time_sample;
    end
    if (ctrl.start_draw) begin
      w_nxt = in_time_sample;
    end
    if (ctrl.run) begin
      w_nxt = mix_w;
      s_nxt = mix_s;
    end
  end

  // Result register: a seed load returns zero, a draw the last working word.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.load_seed) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
    end else if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = mix_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

`default_nettype wire

// ===== hdl/rmrg_checker.sv =====
// Port-level checks of the rotate-mix random generator, bound to its top level.
// Depends on rmrg_pkg for the word width.
`default_nettype none

module rmrg_checker
  import rmrg_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             in_mode,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [WordW-1:0] out_random_word
);

  // A draw keeps the input closed on the following cycle.
  a_draw_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("input ready right after a draw was accepted");

  // A seed load answers with a zero word on the next cycle.
  a_load_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> out_valid && (out_random_word == '0))
    else $error("seed load did not return a zero word");

  // A draw runs at least 32 rounds of four steps before its word shows.
  a_draw_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |-> ##127 !out_valid)
    else $error("draw finished in fewer than 32 rounds");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word))
    else $error("stalled result word changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rotate_mix_random_generator rmrg_checker u_rmrg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_random_word (out_random_word)
);

`default_nettype wire
